[src/assert_macros.svh]
// Assertion macros included by the pruner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define KC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define KC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[src/kcbp_pkg.sv]
// Package for the candidate bound pruner: defaults, command and status codes.
package kcbp_pkg;

   localparam int ENTRIES_DEF   = 64;
   localparam int DIST_BITS_DEF = 32;
   localparam int ID_W          = 31;
   localparam int K_W           = 7;
   localparam logic [K_W-1:0] K_RESET = 7'd3;

   typedef enum logic [1:0] {
      MODE_MERGE = 2'd0,
      MODE_EXACT = 2'd1,
      MODE_PRUNE = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

endpackage

[src/knn_candidate_bound_pruner.sv]
// Candidate bound table with merge, exact set, k-th bound prune and slot read.
//
// Usage:
//  - Command channel: drive req_* and raise start while busy is low; the item
//    is taken at that clock edge. busy stays high until the result is out.
//  - Result channel: rsp_valid is high for exactly one cycle with rsp_*;
//    the receiver cannot hold results off, so it must sample on that strobe.
//  - Config: csr_k_nearest is written when csr_valid and csr_ready are both
//    high; csr_ready is always high. Write it only while the block is idle.
//  - Table lives in one ENTRIES-deep memory {valid, id, low, high}, read one
//    entry per cycle with a registered read.
//  - Merge / exact: one scan of the table (id match and first free slot),
//    then one read-modify-write.
//  - Prune: one scan builds the k smallest upper bounds in a sorted register
//    row, a second scan clears entries whose lower bound is above the k-th.
//  - The memory scan (one entry per cycle through the single read port) sets
//    the item time.
//  - Reset: a clearing pass writes every entry invalid with busy high;
//    k_nearest returns to 3, live count and threshold to 0.
`include "assert_macros.svh"

module knn_candidate_bound_pruner #(
   parameter int ENTRIES   = kcbp_pkg::ENTRIES_DEF,
   parameter int DIST_BITS = kcbp_pkg::DIST_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // command channel
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_mode,
   input  logic [kcbp_pkg::ID_W-1:0]  req_cand_id,
   input  logic [5:0]                 req_slot_index,
   input  logic [31:0]                req_low_dist,
   input  logic [31:0]                req_high_dist,
   // result channel
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_entry_valid,
   output logic [kcbp_pkg::ID_W-1:0]  rsp_out_id,
   output logic [31:0]                rsp_out_low,
   output logic [31:0]                rsp_out_high,
   output logic [31:0]                rsp_prune_threshold,
   output logic [6:0]                 rsp_live_entries,
   output logic [6:0]                 rsp_removed_entries,
   // config write channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [kcbp_pkg::K_W-1:0]   csr_k_nearest
);

   localparam int DW   = DIST_BITS;
   localparam int AW   = $clog2(ENTRIES);
   localparam int CW   = $clog2(ENTRIES + 1);
   // k can never exceed the live count, nor the 7-bit register value
   localparam int KEEP = (ENTRIES < 127) ? ENTRIES : 127;
   localparam int KW   = $clog2(KEEP + 1);
   localparam int XW   = (CW > kcbp_pkg::K_W) ? CW : kcbp_pkg::K_W;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_FIND, ST_MERGE, ST_SELECT, ST_PRUNE, ST_READ
   } state_type;

   typedef struct packed {
      logic                      valid;
      logic [kcbp_pkg::ID_W-1:0] id;
      logic [DW-1:0]             low;
      logic [DW-1:0]             high;
   } slot_type;

   // ---------------------------------------------------------------
   // Table memory: one write port, one registered read port
   // ---------------------------------------------------------------
   slot_type          mem [ENTRIES];
   slot_type          rd_data_ff;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   slot_type          mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   state_type                 state_ff, state_in;
   logic [CW-1:0]             iss_ff, iss_in;           // next address to read
   logic                      pend_ff, pend_in;         // rd_data_ff holds a scan entry
   logic [AW-1:0]             pend_addr_ff, pend_addr_in;
   kcbp_pkg::mode_type        mode_ff, mode_in;
   logic [kcbp_pkg::ID_W-1:0] id_ff, id_in;
   logic [DW-1:0]             low_ff, low_in;
   logic [DW-1:0]             high_ff, high_in;
   logic [kcbp_pkg::K_W-1:0]  k_ff, k_in;
   logic [CW-1:0]             live_ff, live_in;
   logic [DW-1:0]             thr_ff, thr_in;           // last prune threshold
   logic [CW-1:0]             removed_ff, removed_in;
   logic                      hit_ff, hit_in;
   logic [AW-1:0]             hit_addr_ff, hit_addr_in;
   logic [DW-1:0]             hit_low_ff, hit_low_in;
   logic [DW-1:0]             hit_high_ff, hit_high_in;
   logic                      free_ff, free_in;
   logic [AW-1:0]             free_addr_ff, free_addr_in;
   logic                      in_range_ff, in_range_in;
   logic [KW-1:0]             keff_ff, keff_in;
   logic [KW-1:0]             sel_cnt_ff, sel_cnt_in;
   logic [DW-1:0]             sel_list_ff [KEEP];       // sorted, largest at 0
   logic [DW-1:0]             sel_list_in [KEEP];

   logic                      rsp_valid_ff, rsp_valid_in;
   kcbp_pkg::status_type      rsp_status_ff, rsp_status_in;
   logic                      rsp_ev_ff, rsp_ev_in;
   logic [kcbp_pkg::ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic [31:0]               rsp_low_ff, rsp_low_in;
   logic [31:0]               rsp_high_ff, rsp_high_in;
   logic [31:0]               rsp_thr_ff, rsp_thr_in;
   logic [6:0]                rsp_live_ff, rsp_live_in;
   logic [6:0]                rsp_removed_ff, rsp_removed_in;

   // ---------------------------------------------------------------
   // k-smallest selection row: one insert or replace per scanned entry
   // ---------------------------------------------------------------
   logic [DW-1:0]  sel_v;
   logic           sel_gt   [KEEP];
   logic [DW-1:0]  sel_next [KEEP];
   logic           sel_ins;
   logic           sel_rep;

   assign sel_v   = rd_data_ff.high;
   assign sel_ins = (sel_cnt_ff < keff_ff);
   assign sel_rep = !sel_ins && sel_gt[0];

   for (genvar j = 0; j < KEEP; j++) begin : g_sel
      logic [DW-1:0] below_val;
      logic          below_gt;
      logic [DW-1:0] above_val;
      logic          above_gt;

      assign sel_gt[j] = (KW'(j) < sel_cnt_ff) && (sel_list_ff[j] > sel_v);

      if (j == 0) begin : g_first
         assign below_val = sel_v;
         assign below_gt  = 1'b1;
      end else begin : g_mid
         assign below_val = sel_list_ff[j-1];
         assign below_gt  = sel_gt[j-1];
      end

      if (j == KEEP - 1) begin : g_last
         assign above_val = sel_v;
         assign above_gt  = 1'b0;
      end else begin : g_inner
         assign above_val = sel_list_ff[j+1];
         assign above_gt  = sel_gt[j+1];
      end

      // insert: larger ones stay, smaller ones move up one place
      // replace: drop the largest, larger ones move down one place
      assign sel_next[j] = sel_ins ?
                           (sel_gt[j] ? sel_list_ff[j] : (below_gt ? sel_v : below_val)) :
                           (above_gt ? above_val : (sel_gt[j] ? sel_v : sel_list_ff[j]));
   end

   // ---------------------------------------------------------------
   // Next-state logic
   // ---------------------------------------------------------------
   logic                        iss_done;
   logic [kcbp_pkg::K_W-1:0]    k_clip;
   logic [XW-1:0]               k_ext;
   logic [XW-1:0]               live_ext;
   logic [DW-1:0]               new_low;
   logic [DW-1:0]               new_high;

   assign iss_done  = (iss_ff == CW'(ENTRIES));
   assign k_clip    = (k_ff == '0) ? kcbp_pkg::K_W'(1) : k_ff;
   assign k_ext     = XW'(k_clip);
   assign live_ext  = XW'(live_ff);
   assign new_low   = (mode_ff == kcbp_pkg::MODE_MERGE && hit_low_ff >= low_ff) ?
                      hit_low_ff : low_ff;
   assign new_high  = (mode_ff == kcbp_pkg::MODE_MERGE && hit_high_ff <= high_ff) ?
                      hit_high_ff : high_ff;

   always_comb begin
      state_in       = state_ff;
      iss_in         = iss_ff;
      pend_in        = 1'b0;
      pend_addr_in   = iss_ff[AW-1:0];
      mode_in        = mode_ff;
      id_in          = id_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      k_in           = k_ff;
      live_in        = live_ff;
      thr_in         = thr_ff;
      removed_in     = removed_ff;
      hit_in         = hit_ff;
      hit_addr_in    = hit_addr_ff;
      hit_low_in     = hit_low_ff;
      hit_high_in    = hit_high_ff;
      free_in        = free_ff;
      free_addr_in   = free_addr_ff;
      in_range_in    = in_range_ff;
      keff_in        = keff_ff;
      sel_cnt_in     = sel_cnt_ff;
      sel_list_in    = sel_list_ff;

      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_ev_in      = rsp_ev_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_low_in     = rsp_low_ff;
      rsp_high_in    = rsp_high_ff;
      rsp_thr_in     = rsp_thr_ff;
      rsp_live_in    = rsp_live_ff;
      rsp_removed_in = rsp_removed_ff;

      mem_re         = 1'b0;
      mem_raddr      = iss_ff[AW-1:0];
      mem_we         = 1'b0;
      mem_waddr      = pend_addr_ff;
      mem_wdata      = rd_data_ff;

      if (csr_valid) begin
         k_in = csr_k_nearest;
      end

      // scan states: issue one read per cycle until the table is covered
      if ((state_ff == ST_FIND || state_ff == ST_SELECT || state_ff == ST_PRUNE) &&
          !iss_done) begin
         mem_re  = 1'b1;
         pend_in = 1'b1;
         iss_in  = iss_ff + 1'b1;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = iss_ff[AW-1:0];
            mem_wdata = '0;
            if (iss_ff == CW'(ENTRIES - 1)) begin
               iss_in   = '0;
               state_in = ST_IDLE;
            end else begin
               iss_in = iss_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (start) begin
               mode_in     = kcbp_pkg::mode_type'(req_mode);
               id_in       = req_cand_id;
               low_in      = DW'(req_low_dist);
               high_in     = (req_mode == kcbp_pkg::MODE_EXACT) ?
                             DW'(req_low_dist) : DW'(req_high_dist);
               iss_in      = '0;
               hit_in      = 1'b0;
               free_in     = 1'b0;
               removed_in  = '0;
               sel_cnt_in  = '0;
               keff_in     = KW'((k_ext < live_ext) ? k_ext : live_ext);
               in_range_in = (32'(req_slot_index) < 32'(ENTRIES));
               case (kcbp_pkg::mode_type'(req_mode)) inside
                  kcbp_pkg::MODE_MERGE, kcbp_pkg::MODE_EXACT: begin
                     state_in = ST_FIND;
                  end
                  kcbp_pkg::MODE_PRUNE: begin
                     state_in = ST_SELECT;
                  end
                  default: begin
                     mem_re    = 1'b1;
                     mem_raddr = AW'(req_slot_index);
                     state_in  = ST_READ;
                  end
               endcase
            end
         end

         ST_FIND: begin
            if (pend_ff) begin
               if (rd_data_ff.valid && rd_data_ff.id == id_ff && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_addr_in = pend_addr_ff;
                  hit_low_in  = rd_data_ff.low;
                  hit_high_in = rd_data_ff.high;
               end
               if (!rd_data_ff.valid && !free_ff) begin
                  free_in      = 1'b1;
                  free_addr_in = pend_addr_ff;
               end
            end
            if (iss_done && !pend_ff) begin
               state_in = ST_MERGE;
            end
         end

         ST_MERGE: begin
            rsp_status_in = kcbp_pkg::STAT_OK;
            rsp_ev_in     = 1'b1;
            rsp_id_in     = id_ff;
            if (hit_ff) begin
               mem_we         = 1'b1;
               mem_waddr      = hit_addr_ff;
               mem_wdata.valid = 1'b1;
               mem_wdata.id   = id_ff;
               mem_wdata.low  = new_low;
               mem_wdata.high = new_high;
               rsp_low_in     = 32'(new_low);
               rsp_high_in    = 32'(new_high);
            end else if (free_ff) begin
               mem_we         = 1'b1;
               mem_waddr      = free_addr_ff;
               mem_wdata.valid = 1'b1;
               mem_wdata.id   = id_ff;
               mem_wdata.low  = low_ff;
               mem_wdata.high = high_ff;
               live_in        = live_ff + 1'b1;
               rsp_low_in     = 32'(low_ff);
               rsp_high_in    = 32'(high_ff);
            end else begin
               // table full: echo the offered item, table untouched
               rsp_status_in  = kcbp_pkg::STAT_FULL;
               rsp_ev_in      = 1'b0;
               rsp_low_in     = 32'(low_ff);
               rsp_high_in    = 32'(high_ff);
            end
            rsp_valid_in   = 1'b1;
            rsp_thr_in     = 32'(thr_ff);
            rsp_live_in    = 7'(live_in);
            rsp_removed_in = '0;
            state_in       = ST_IDLE;
         end

         ST_SELECT: begin
            if (pend_ff && rd_data_ff.valid && (sel_ins || sel_rep)) begin
               sel_list_in = sel_next;
               if (sel_ins) begin
                  sel_cnt_in = sel_cnt_ff + 1'b1;
               end
            end
            if (iss_done && !pend_ff) begin
               // empty table leaves the row empty: threshold 0
               thr_in   = (sel_cnt_ff == '0) ? '0 : sel_list_ff[0];
               iss_in   = '0;
               state_in = ST_PRUNE;
            end
         end

         ST_PRUNE: begin
            if (pend_ff && rd_data_ff.valid && rd_data_ff.low > thr_ff) begin
               mem_we          = 1'b1;
               mem_wdata.valid = 1'b0;
               removed_in      = removed_ff + 1'b1;
               live_in         = live_ff - 1'b1;
            end
            if (iss_done && !pend_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = kcbp_pkg::STAT_OK;
               rsp_ev_in      = 1'b0;
               rsp_id_in      = '0;
               rsp_low_in     = '0;
               rsp_high_in    = '0;
               rsp_thr_in     = 32'(thr_ff);
               rsp_live_in    = 7'(live_ff);
               rsp_removed_in = 7'(removed_ff);
               state_in       = ST_IDLE;
            end
         end

         ST_READ: begin
            rsp_valid_in   = 1'b1;
            rsp_thr_in     = 32'(thr_ff);
            rsp_live_in    = 7'(live_ff);
            rsp_removed_in = '0;
            if (in_range_ff && rd_data_ff.valid) begin
               rsp_status_in = kcbp_pkg::STAT_OK;
               rsp_ev_in     = 1'b1;
               rsp_id_in     = rd_data_ff.id;
               rsp_low_in    = 32'(rd_data_ff.low);
               rsp_high_in   = 32'(rd_data_ff.high);
            end else begin
               rsp_status_in = kcbp_pkg::STAT_EMPTY;
               rsp_ev_in     = 1'b0;
               rsp_id_in     = '0;
               rsp_low_in    = '0;
               rsp_high_in   = '0;
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // State and registered outputs
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         iss_ff       <= '0;
         pend_ff      <= 1'b0;
         k_ff         <= kcbp_pkg::K_RESET;
         live_ff      <= '0;
         thr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         pend_ff      <= pend_in;
         k_ff         <= k_in;
         live_ff      <= live_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_addr_ff   <= pend_addr_in;
      mode_ff        <= mode_in;
      id_ff          <= id_in;
      low_ff         <= low_in;
      high_ff        <= high_in;
      removed_ff     <= removed_in;
      hit_ff         <= hit_in;
      hit_addr_ff    <= hit_addr_in;
      hit_low_ff     <= hit_low_in;
      hit_high_ff    <= hit_high_in;
      free_ff        <= free_in;
      free_addr_ff   <= free_addr_in;
      in_range_ff    <= in_range_in;
      keff_ff        <= keff_in;
      sel_cnt_ff     <= sel_cnt_in;
      sel_list_ff    <= sel_list_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_ev_ff      <= rsp_ev_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_low_ff     <= rsp_low_in;
      rsp_high_ff    <= rsp_high_in;
      rsp_thr_ff     <= rsp_thr_in;
      rsp_live_ff    <= rsp_live_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_entry_valid     = rsp_ev_ff;
   assign rsp_out_id          = rsp_id_ff;
   assign rsp_out_low         = rsp_low_ff;
   assign rsp_out_high        = rsp_high_ff;
   assign rsp_prune_threshold = rsp_thr_ff;
   assign rsp_live_entries    = rsp_live_ff;
   assign rsp_removed_entries = rsp_removed_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `KC_ASSERT_IMP(a_live_bound, clock, reset, 1'b1, live_ff <= CW'(ENTRIES))
   `KC_ASSERT_NXT(a_single_rsp, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   `KC_ASSERT_IMP(a_no_idle_write, clock, reset, state_ff == ST_IDLE, !mem_we)
   `KC_ASSERT_NXT(a_thr_hold, clock, reset, state_ff != ST_SELECT, $stable(thr_ff))
   `KC_ASSERT_IMP(a_sel_bound, clock, reset, state_ff == ST_SELECT, sel_cnt_ff <= keff_ff)

endmodule
